@@ sv/gvrp_pkg.sv @@
`timescale 1ns / 1ps
package gvrp_pkg;

	localparam int CORDIC_STAGES_DFLT = 14;
	localparam int ATAN_ENTRIES       = 24;

	localparam int AW   = 16;  // angle width, Q3.13
	localparam int CW   = 32;  // CORDIC datapath width, Q28
	localparam int GW   = 14;  // gravity magnitude width
	localparam int OW   = 16;  // result width
	localparam int FRAC = 28;
	// width of a rounded g*t or g*sin result before saturation
	localparam int RW   = GW + CW + 2 - FRAC;

	localparam logic OP_ACCEL = 1'b0;
	localparam logic OP_KINEM = 1'b1;

	localparam logic [GW-1:0]        GRAVITY_RST = 14'd15691;
	localparam logic signed [CW-1:0] Q28_PI      = 32'sd843314857;
	localparam logic signed [CW-1:0] Q28_HALF_PI = 32'sd421657428;
	localparam logic signed [CW-1:0] Q28_GAIN    = 32'sd163008219;

	typedef struct packed {
		logic signed [CW-1:0] sin_v;
		logic signed [CW-1:0] cos_v;
		logic                 flip;
		logic signed [AW-1:0] angle;
	} lane_t;

	typedef struct packed {
		logic signed [OW-1:0] x;
		logic signed [OW-1:0] y;
		logic signed [OW-1:0] z;
	} res_t;

	function automatic logic signed [CW-1:0] gvrp_atan(input int idx);
		logic signed [CW-1:0] r;
		case (idx)
			0:       r = 32'sd210828714;
			1:       r = 32'sd124459457;
			2:       r = 32'sd65760959;
			3:       r = 32'sd33381290;
			4:       r = 32'sd16755422;
			5:       r = 32'sd8385879;
			6:       r = 32'sd4193963;
			7:       r = 32'sd2097109;
			8:       r = 32'sd1048571;
			9:       r = 32'sd524287;
			10:      r = 32'sd262144;
			11:      r = 32'sd131072;
			12:      r = 32'sd65536;
			13:      r = 32'sd32768;
			14:      r = 32'sd16384;
			15:      r = 32'sd8192;
			16:      r = 32'sd4096;
			17:      r = 32'sd2048;
			18:      r = 32'sd1024;
			19:      r = 32'sd512;
			20:      r = 32'sd256;
			21:      r = 32'sd128;
			22:      r = 32'sd64;
			23:      r = 32'sd32;
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic logic signed [OW-1:0] gvrp_sat16(input logic signed [RW-1:0] v);
		logic signed [OW-1:0] r;
		if (v > $signed(RW'(32767))) begin
			r = 16'sh7fff;
		end else if (v < -$signed(RW'(32768))) begin
			r = 16'sh8000;
		end else begin
			r = v[OW-1:0];
		end
		return r;
	endfunction

endpackage

@@ sv/gvrp_cordic.sv @@
`timescale 1ns / 1ps
module gvrp_cordic #(
	parameter int STAGES = gvrp_pkg::CORDIC_STAGES_DFLT
) (
	input  logic                              clk,
	input  logic                              en,
	input  logic signed [gvrp_pkg::AW-1:0]    angle,
	output gvrp_pkg::lane_t                   lane
);
	import gvrp_pkg::*;

	localparam int NS = (STAGES > ATAN_ENTRIES) ? ATAN_ENTRIES : STAGES;

	logic signed [CW-1:0] x_s [0:NS];
	logic signed [CW-1:0] y_s [0:NS];
	logic signed [CW-1:0] z_s [0:NS];
	logic                 fl_s [0:NS];
	logic signed [AW-1:0] ang_s [0:NS];

	logic signed [CW-1:0] z_in;

	// Q3.13 -> Q28
	assign z_in = $signed({angle[AW-1], angle, 15'b0});

	// fold into [-pi/2, pi/2]; the flag negates sin and cos downstream
	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0]   <= Q28_GAIN;
			y_s[0]   <= '0;
			ang_s[0] <= angle;
			if (z_in > Q28_HALF_PI) begin
				z_s[0]  <= z_in - Q28_PI;
				fl_s[0] <= 1'b1;
			end else if (z_in < -Q28_HALF_PI) begin
				z_s[0]  <= z_in + Q28_PI;
				fl_s[0] <= 1'b1;
			end else begin
				z_s[0]  <= z_in;
				fl_s[0] <= 1'b0;
			end
		end
	end

	for (genvar k = 0; k < NS; k++) begin : g_iter
		always_ff @(posedge clk) begin
			if (en) begin
				fl_s[k+1]  <= fl_s[k];
				ang_s[k+1] <= ang_s[k];
				if (!z_s[k][CW-1]) begin
					x_s[k+1] <= x_s[k] - (y_s[k] >>> k);
					y_s[k+1] <= y_s[k] + (x_s[k] >>> k);
					z_s[k+1] <= z_s[k] - gvrp_atan(k);
				end else begin
					x_s[k+1] <= x_s[k] + (y_s[k] >>> k);
					y_s[k+1] <= y_s[k] - (x_s[k] >>> k);
					z_s[k+1] <= z_s[k] + gvrp_atan(k);
				end
			end
		end
	end

	assign lane.sin_v = y_s[NS];
	assign lane.cos_v = x_s[NS];
	assign lane.flip  = fl_s[NS];
	assign lane.angle = ang_s[NS];

endmodule

@@ sv/gvrp_merge.sv @@
`timescale 1ns / 1ps
module gvrp_merge (
	input  logic                       clk,
	input  logic                       en,
	input  logic [gvrp_pkg::GW-1:0]    gravity,
	input  logic                       op_in,
	input  gvrp_pkg::lane_t            lane_r,
	input  gvrp_pkg::lane_t            lane_p,
	output gvrp_pkg::res_t             res
);
	import gvrp_pkg::*;

	localparam int PW = 2 * CW;      // sin*cos product
	localparam int GPW = GW + 1 + CW; // g*value product

	localparam logic signed [PW:0]  HALF_P = (PW + 1)'(1) <<< (FRAC - 1);
	localparam logic signed [GPW:0] HALF_G = (GPW + 1)'(1) <<< (FRAC - 1);

	logic signed [GW:0] g_sgn;
	assign g_sgn = $signed({1'b0, gravity});

	// stage 1: products
	logic signed [PW-1:0]  pa_s1, pb_s1;
	logic signed [GPW-1:0] pc_s1;
	logic                  neg_s1, negx_s1, op_s1;
	logic signed [AW-1:0]  ra_s1, pang_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			pa_s1   <= $signed(lane_r.sin_v) * $signed(lane_p.cos_v);
			pb_s1   <= $signed(lane_r.cos_v) * $signed(lane_p.cos_v);
			pc_s1   <= g_sgn * $signed(lane_p.sin_v);
			neg_s1  <= lane_r.flip ^ lane_p.flip;
			negx_s1 <= lane_p.flip;
			op_s1   <= op_in;
			ra_s1   <= lane_r.angle;
			pang_s1 <= lane_p.angle;
		end
	end

	// stage 2: round the products to Q28 and x to a saturated result, folding the quadrant sign into the rounding add
	logic signed [PW:0]    va, vb;
	logic signed [GPW:0]   vx;
	logic signed [CW-1:0]  ta_s2, tb_s2;
	logic signed [OW-1:0]  x_s2;
	logic                  op_s2;
	logic signed [AW-1:0]  ra_s2, pang_s2;

	always_comb begin
		va = neg_s1  ? HALF_P - pa_s1 : pa_s1 + HALF_P;
		vb = neg_s1  ? HALF_P - pb_s1 : pb_s1 + HALF_P;
		vx = negx_s1 ? HALF_G - pc_s1 : pc_s1 + HALF_G;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ta_s2   <= $signed(va[CW+FRAC-1:FRAC]);
			tb_s2   <= $signed(vb[CW+FRAC-1:FRAC]);
			x_s2    <= gvrp_sat16($signed(vx[GPW:FRAC]));
			op_s2   <= op_s1;
			ra_s2   <= ra_s1;
			pang_s2 <= pang_s1;
		end
	end

	// stage 3: scale by gravity
	logic signed [GPW-1:0] qa_s3, qb_s3;
	logic signed [OW-1:0]  x_s3;
	logic                  op_s3;
	logic signed [AW-1:0]  ra_s3, pang_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			qa_s3   <= g_sgn * ta_s2;
			qb_s3   <= g_sgn * tb_s2;
			x_s3    <= x_s2;
			op_s3   <= op_s2;
			ra_s3   <= ra_s2;
			pang_s3 <= pang_s2;
		end
	end

	// negate, round and saturate y and z; select kinematic pass-through
	logic signed [GPW:0] vy, vz;

	always_comb begin
		vy = HALF_G - qa_s3;
		vz = HALF_G - qb_s3;
		if (op_s3 == OP_KINEM) begin
			res.x = ra_s3;
			res.y = pang_s3;
			res.z = '0;
		end else begin
			res.x = x_s3;
			res.y = gvrp_sat16($signed(vy[GPW:FRAC]));
			res.z = gvrp_sat16($signed(vz[GPW:FRAC]));
		end
	end

endmodule

@@ sv/gravity_vector_from_roll_pitch.sv @@
`timescale 1ns / 1ps
// Gravity-vector prediction for a tilt filter.
// Input channel (in_valid/in_ready): op, roll_angle, pitch_angle in Q3.13 rad.
//   op 0 gives out_x = g*sinP, out_y = -g*sinR*cosP, out_z = -g*cosR*cosP
//   in 1/16 cm/s^2, saturated to 16 bits; op 1 passes roll and pitch to
//   out_x and out_y with out_z zero.
// Output channel (out_valid/out_ready): one beat per input beat, in order.
// Config: cfg_wr_en writes cfg_wr_data into the gravity magnitude at once;
//   write it only while no beat is in flight.
// Throughput: one beat per cycle while in_ready is high. Roll and pitch each
//   run through their own pipelined CORDIC lane (one fold stage plus
//   CORDIC_STAGES rotation stages, at most 24), then three merge stages and
//   the output register.
// Stall: while an output beat waits with out_ready low, the next finished
//   beat parks in a skid register; in_ready drops only while that register
//   is full, and the whole pipeline holds until the output beat is taken.
// Reset: arst_n clears all valid flags and loads the gravity magnitude with
//   980.7 cm/s^2 (15691); in_ready is already high when reset ends.
module gravity_vector_from_roll_pitch #(
	parameter int CORDIC_STAGES = gvrp_pkg::CORDIC_STAGES_DFLT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [gvrp_pkg::GW-1:0]           cfg_wr_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              op,
	input  logic signed [gvrp_pkg::AW-1:0]    roll_angle,
	input  logic signed [gvrp_pkg::AW-1:0]    pitch_angle,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [gvrp_pkg::OW-1:0]    out_x,
	output logic signed [gvrp_pkg::OW-1:0]    out_y,
	output logic signed [gvrp_pkg::OW-1:0]    out_z
);
	import gvrp_pkg::*;

	localparam int NS = (CORDIC_STAGES > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STAGES;
	localparam int L  = NS + 4;

	logic [GW-1:0] gravity_q;
	logic [L-1:0]  vld_s;
	logic [NS:0]   op_s;
	logic          en;
	lane_t         lane_r, lane_p;
	res_t          res, out_q, skid_q;
	logic          out_vld_q, skid_vld_q;

	assign en       = !skid_vld_q;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gravity_q <= GRAVITY_RST;
		end else if (cfg_wr_en) begin
			gravity_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[L-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s <= {op_s[NS-1:0], op};
		end
	end

	gvrp_cordic #(.STAGES(CORDIC_STAGES)) u_lane_roll (
		.clk   (clk),
		.en    (en),
		.angle (roll_angle),
		.lane  (lane_r)
	);

	gvrp_cordic #(.STAGES(CORDIC_STAGES)) u_lane_pitch (
		.clk   (clk),
		.en    (en),
		.angle (pitch_angle),
		.lane  (lane_p)
	);

	gvrp_merge u_merge (
		.clk     (clk),
		.en      (en),
		.gravity (gravity_q),
		.op_in   (op_s[NS]),
		.lane_r  (lane_r),
		.lane_p  (lane_p),
		.res     (res)
	);

	// output register plus skid register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			if (out_ready) begin
				skid_vld_q <= 1'b0;
			end
		end else if (vld_s[L-1]) begin
			if (out_vld_q && !out_ready) begin
				skid_vld_q <= 1'b1;
			end else begin
				out_vld_q <= 1'b1;
			end
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_vld_q) begin
			if (out_ready) begin
				out_q <= skid_q;
			end
		end else if (vld_s[L-1]) begin
			if (out_vld_q && !out_ready) begin
				skid_q <= res;
			end else begin
				out_q <= res;
			end
		end
	end

	assign out_valid = out_vld_q;
	assign out_x     = out_q.x;
	assign out_y     = out_q.y;
	assign out_z     = out_q.z;

endmodule

@@ sv/gvrp_checker.sv @@
`timescale 1ns / 1ps
module gvrp_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_ready,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic signed [gvrp_pkg::OW-1:0]    out_x,
	input logic signed [gvrp_pkg::OW-1:0]    out_y,
	input logic signed [gvrp_pkg::OW-1:0]    out_z
);

	// hold a stalled output beat
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_y)
			&& $stable(out_z))
		else $error("output beat changed while stalled");

	// reset leaves no output beat and an open input
	a_rst_quiet: assert property (@(posedge clk)
		!arst_n |=> !out_valid && in_ready)
		else $error("handshake active in reset");

	// input backpressure only follows an output stall
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> $past(out_valid && !out_ready))
		else $error("in_ready dropped without an output stall");

	// a taken beat frees the skid register
	a_ready_back: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !in_ready |=> in_ready && out_valid)
		else $error("input side did not resume after output beat");

endmodule

bind gravity_vector_from_roll_pitch gvrp_checker u_gvrp_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.out_x       (out_x),
	.out_y       (out_y),
	.out_z       (out_z)
);

@@ test/gravity_vector_from_roll_pitch_tb.sv @@
`timescale 1ns / 1ps
module gravity_vector_from_roll_pitch_tb;

	import gvrp_pkg::*;

	localparam int STAGES     = CORDIC_STAGES_DFLT;
	localparam int PIPE_LAT   = STAGES + 4;
	localparam int IDLE_PCT   = 23;
	localparam int STALL_MAX  = 3000;

	localparam longint ANG_PI      = 64'sd843314857;
	localparam longint ANG_HALF_PI = 64'sd421657428;
	localparam longint CORDIC_K    = 64'sd163008219;
	localparam longint HALF_LSB    = 64'sd134217728;

	typedef struct packed {
		logic                 op;
		logic signed [AW-1:0] roll;
		logic signed [AW-1:0] pitch;
	} tilt_beat_t;

	longint atan_q28 [0:23] = '{
		64'sd210828714, 64'sd124459457, 64'sd65760959, 64'sd33381290,
		64'sd16755422, 64'sd8385879, 64'sd4193963, 64'sd2097109,
		64'sd1048571, 64'sd524287, 64'sd262144, 64'sd131072,
		64'sd65536, 64'sd32768, 64'sd16384, 64'sd8192,
		64'sd4096, 64'sd2048, 64'sd1024, 64'sd512,
		64'sd256, 64'sd128, 64'sd64, 64'sd32
	};

	logic                 clk;
	logic                 arst_n      = 1'b0;
	logic                 cfg_wr_en   = 1'b0;
	logic [GW-1:0]        cfg_wr_data = '0;
	logic                 in_valid    = 1'b0;
	logic                 in_ready;
	logic                 op          = OP_ACCEL;
	logic signed [AW-1:0] roll_angle  = '0;
	logic signed [AW-1:0] pitch_angle = '0;
	logic                 out_valid;
	logic                 out_ready   = 1'b0;
	logic signed [OW-1:0] out_x;
	logic signed [OW-1:0] out_y;
	logic signed [OW-1:0] out_z;

	tilt_beat_t    beat_pending_q [$];
	res_t          gravity_expect_q [$];
	logic [GW-1:0] gravity_now = GRAVITY_RST;
	bit            steady      = 1'b0;
	int            error_count = 0;
	int            quiet_cycles = 0;
	tilt_beat_t    drv_beat;
	tilt_beat_t    taken_beat;
	res_t          want;
	res_t          head_want;

	gravity_vector_from_roll_pitch uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.op          (op),
		.roll_angle  (roll_angle),
		.pitch_angle (pitch_angle),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_x       (out_x),
		.out_y       (out_y),
		.out_z       (out_z)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic longint round_q28(input longint v);
		return (v + HALF_LSB) >>> 28;
	endfunction

	function automatic logic signed [OW-1:0] clamp16(input longint v);
		if (v > 32767) begin
			return 16'sh7fff;
		end else if (v < -32768) begin
			return 16'sh8000;
		end
		return v[OW-1:0];
	endfunction

	// sin and cos in Q28 of a Q3.13 angle
	task automatic sin_cos_q28(input logic signed [AW-1:0] ang, output longint s,
			output longint c);
		longint z;
		longint x;
		longint y;
		longint nx;
		bit     flip;
		int     n;
		z = longint'(ang) * 32768;
		x = CORDIC_K;
		y = 0;
		flip = 1'b0;
		n = (STAGES > 24) ? 24 : STAGES;
		// fold into [-pi/2, pi/2], negate afterwards
		if (z > ANG_HALF_PI) begin
			z = z - ANG_PI;
			flip = 1'b1;
		end else if (z < -ANG_HALF_PI) begin
			z = z + ANG_PI;
			flip = 1'b1;
		end
		for (int i = 0; i < n; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				z = z - atan_q28[i];
			end else begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				z = z + atan_q28[i];
			end
			x = nx;
		end
		if (flip) begin
			x = -x;
			y = -y;
		end
		s = y;
		c = x;
	endtask

	task automatic predict_gravity(input tilt_beat_t b, input logic [GW-1:0] gmag,
			output res_t r);
		longint g;
		longint sr;
		longint cr;
		longint sp;
		longint cp;
		longint t;
		g = longint'(gmag);
		if (b.op == OP_KINEM) begin
			r.x = clamp16(longint'(b.roll));
			r.y = clamp16(longint'(b.pitch));
			r.z = '0;
		end else begin
			sin_cos_q28(b.roll, sr, cr);
			sin_cos_q28(b.pitch, sp, cp);
			r.x = clamp16(round_q28(g * sp));
			t = round_q28(sr * cp);
			r.y = clamp16(round_q28(-(g * t)));
			t = round_q28(cr * cp);
			r.z = clamp16(round_q28(-(g * t)));
		end
	endtask

	function automatic void queue_beat(input logic o, input int r, input int p);
		tilt_beat_t b;
		b.op = o;
		b.roll = AW'(r);
		b.pitch = AW'(p);
		beat_pending_q.push_back(b);
	endfunction

	function automatic int pick_angle();
		int k;
		int base;
		k = $urandom_range(5);
		base = $urandom_range(1) ? 12868 : 25736;
		case (k)
			0, 1, 2: begin
				return int'($signed(16'($urandom)));
			end
			3: begin
				// near the fold thresholds and the pi wrap
				base = base + $urandom_range(8) - 4;
				return $urandom_range(1) ? base : -base;
			end
			4: begin
				return $urandom_range(1) ? 32767 - $urandom_range(3) : -32768 + $urandom_range(3);
			end
			default: begin
				return $urandom_range(400) - 200;
			end
		endcase
	endfunction

	task automatic drain_pipe();
		while (beat_pending_q.size() > 0 || gravity_expect_q.size() > 0 || in_valid) begin
			@(negedge clk);
		end
		repeat (PIPE_LAT + 4) @(posedge clk);
	endtask

	task automatic write_gravity(input logic [GW-1:0] val);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		gravity_now = val;
	endtask

	task automatic random_phase(input logic [GW-1:0] gmag, input int count, input bit no_gaps);
		write_gravity(gmag);
		steady = no_gaps;
		for (int i = 0; i < count; i++) begin
			queue_beat(($urandom_range(99) < 20) ? OP_KINEM : OP_ACCEL, pick_angle(),
				pick_angle());
		end
		drain_pipe();
		steady = 1'b0;
	endtask

	// driver: hold the beat until taken, then advance
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				taken_beat.op = op;
				taken_beat.roll = roll_angle;
				taken_beat.pitch = pitch_angle;
				predict_gravity(taken_beat, gravity_now, want);
				gravity_expect_q.push_back(want);
			end
			if (!in_valid || in_ready) begin
				if (beat_pending_q.size() > 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
					drv_beat = beat_pending_q.pop_front();
					in_valid <= 1'b1;
					op <= drv_beat.op;
					roll_angle <= drv_beat.roll;
					pitch_angle <= drv_beat.pitch;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: compare each taken result beat with the oldest prediction
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (gravity_expect_q.size() == 0) begin
					$display("%0t: unexpected beat x=%0d y=%0d z=%0d", $time, out_x, out_y, out_z);
					error_count++;
				end else begin
					head_want = gravity_expect_q.pop_front();
					if (out_x !== head_want.x) begin
						$display("%0t: out_x expected %0d actual %0d", $time, head_want.x, out_x);
						error_count++;
					end
					if (out_y !== head_want.y) begin
						$display("%0t: out_y expected %0d actual %0d", $time, head_want.y, out_y);
						error_count++;
					end
					if (out_z !== head_want.z) begin
						$display("%0t: out_z expected %0d actual %0d", $time, head_want.z, out_z);
						error_count++;
					end
				end
			end
			out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet_cycles <= 0;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
			if (quiet_cycles >= STALL_MAX) begin
				$display("%0t: timeout, no beat moved for %0d cycles", $time, quiet_cycles);
				$display("FAIL gravity_vector_from_roll_pitch");
				$finish;
			end
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset magnitude: fold thresholds, pi wrap, range extremes, pass-through
		queue_beat(OP_ACCEL, 0, 0);
		queue_beat(OP_ACCEL, 12867, 12867);
		queue_beat(OP_ACCEL, 12868, 12868);
		queue_beat(OP_ACCEL, -12867, -12868);
		queue_beat(OP_ACCEL, -12868, -12867);
		queue_beat(OP_ACCEL, 25735, -25735);
		queue_beat(OP_ACCEL, 25736, -25736);
		queue_beat(OP_ACCEL, 32767, 32767);
		queue_beat(OP_ACCEL, -32768, -32768);
		queue_beat(OP_ACCEL, 32767, -32768);
		queue_beat(OP_ACCEL, -32768, 32767);
		queue_beat(OP_ACCEL, 6434, -6434);
		queue_beat(OP_ACCEL, 12868, 0);
		queue_beat(OP_ACCEL, 0, 12868);
		queue_beat(OP_ACCEL, -1, 1);
		queue_beat(OP_KINEM, 32767, -32768);
		queue_beat(OP_KINEM, -32768, 32767);
		queue_beat(OP_KINEM, 0, 0);
		queue_beat(OP_KINEM, -1, 1);
		drain_pipe();

		random_phase(GW'(0), 100, 1'b0);
		random_phase(GW'(16383), 220, 1'b0);
		random_phase(GW'(1), 100, 1'b0);
		random_phase(GW'($urandom), 300, 1'b1);
		for (int k = 0; k < 4; k++) begin
			random_phase(GW'($urandom), 200, 1'b0);
		end
		random_phase(GRAVITY_RST, 130, 1'b0);

		if (error_count == 0) begin
			$display("PASS gravity_vector_from_roll_pitch");
		end else begin
			$display("FAIL gravity_vector_from_roll_pitch");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
sv/gvrp_pkg.sv
sv/gvrp_cordic.sv
sv/gvrp_merge.sv
sv/gravity_vector_from_roll_pitch.sv
sv/gvrp_checker.sv
test/gravity_vector_from_roll_pitch_tb.sv
